FILE: sv/ps2md_pkg.sv
// package: shared types and constants of the ps2 mouse packet decoder
package ps2md_pkg;

    localparam int AUX_DATA_BIT = 5;
    localparam logic [1:0] LAST_BYTE_POS = 2'd2;
    localparam int BUTTON_COUNT = 3;

    typedef enum logic [1:0] {
        KIND_MOVE    = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2
    } event_kind_t;

    // one completed packet as handed from front to back
    typedef struct packed {
        logic                    move;
        logic [7:0]              dx;
        logic [7:0]              dy_raw;
        logic [BUTTON_COUNT-1:0] changed;
        logic [BUTTON_COUNT-1:0] buttons;
    } cmd_t;

    // queue handshake seen by one side
    typedef struct packed {
        logic valid;
        logic ready;
    } qhs_t;

endpackage

FILE: sv/ps2md_in_if.sv
// interface: input channel carrying one controller transaction
interface ps2md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] data_byte;

    modport source (output valid, output status_byte, output data_byte, input ready);
    modport sink (input valid, input status_byte, input data_byte, output ready);
endinterface

FILE: sv/ps2md_out_if.sv
// interface: output channel carrying one decoded mouse event
interface ps2md_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic signed [7:0] delta_x;
    logic signed [8:0] delta_y;
    logic [1:0]        button_number;
    logic              last_event;

    modport source (output valid, output event_kind, output delta_x, output delta_y,
                    output button_number, output last_event, input ready);
    modport sink (input valid, input event_kind, input delta_x, input delta_y,
                  input button_number, input last_event, output ready);
endinterface

FILE: sv/ps2md_front.sv
// front: accepts controller transactions, assembles packets, classifies changes
module ps2md_front
    import ps2md_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       events_enabled,
    ps2md_in_if.sink   pkt_in,
    output logic       push,
    output cmd_t       push_cmd,
    input  logic       push_ready
);

    logic [7:0]              pkt_reg [0:2];
    logic [1:0]              pos_reg, pos_next;
    logic [BUTTON_COUNT-1:0] prev_reg, prev_next;
    logic                    fire;
    logic                    complete;

    assign pkt_in.ready = push_ready;
    assign fire = pkt_in.valid && pkt_in.ready && pkt_in.status_byte[AUX_DATA_BIT];
    assign complete = fire && (pos_reg == LAST_BYTE_POS);

    always_comb
    begin
        pos_next = pos_reg;
        prev_next = prev_reg;
        push_cmd.dx = pkt_reg[1];
        push_cmd.dy_raw = pkt_in.data_byte;
        push_cmd.move = (|pkt_reg[1]) || (|pkt_in.data_byte);
        push_cmd.buttons = pkt_reg[0][BUTTON_COUNT-1:0];
        push_cmd.changed = pkt_reg[0][BUTTON_COUNT-1:0] ^ prev_reg;
        push = complete && events_enabled && (push_cmd.move || (|push_cmd.changed));
        if (fire)
        begin
            pos_next = (pos_reg >= LAST_BYTE_POS) ? 2'd0 : pos_reg + 2'd1;
        end
        if (complete && events_enabled)
        begin
            prev_next = push_cmd.buttons;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            prev_reg <= prev_next;
        end
    end

    // packet bytes need no reset, each is written before it is read
    always_ff @(posedge clk)
    begin
        if (fire && (pos_reg <= LAST_BYTE_POS))
        begin
            pkt_reg[pos_reg] <= pkt_in.data_byte;
        end
    end

endmodule

FILE: sv/ps2md_queue.sv
// queue: two-entry fifo of completed packets between front and back
module ps2md_queue
    import ps2md_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic pop_valid
);

    cmd_t       mem_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    qhs_t       wr_hs, rd_hs;

    assign wr_hs.valid = push;
    assign wr_hs.ready = (count_reg != 2'd2);
    assign rd_hs.valid = (count_reg != 2'd0);
    assign rd_hs.ready = pop;
    assign push_ready = wr_hs.ready;
    assign pop_valid = rd_hs.valid;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (wr_hs.valid && wr_hs.ready)
        begin
            wr_ptr_next = ~wr_ptr_reg;
            count_next = count_next + 2'd1;
        end
        if (rd_hs.valid && rd_hs.ready)
        begin
            rd_ptr_next = ~rd_ptr_reg;
            count_next = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hs.valid && wr_hs.ready)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/ps2md_back.sv
// back: turns one packet command into move and button events, one per cycle unless evt_out stalls
module ps2md_back
    import ps2md_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    input  cmd_t       pop_cmd,
    output logic       pop,
    ps2md_out_if.source evt_out
);

    cmd_t                    cmd_reg, cmd_next;
    logic                    move_pend_reg, move_pend_next;
    logic [BUTTON_COUNT-1:0] btn_pend_reg, btn_pend_next;
    logic [BUTTON_COUNT-1:0] btn_rem;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              kind_reg, kind_next;
    logic [7:0]              dx_reg, dx_next;
    logic [8:0]              dy_reg, dy_next;
    logic [1:0]              btn_reg, btn_next;
    logic                    last_reg, last_next;
    logic                    busy, slot_free, emit, last_now;

    assign busy = move_pend_reg || (|btn_pend_reg);
    assign slot_free = !out_valid_reg || evt_out.ready;
    assign emit = busy && slot_free;
    assign btn_rem = btn_pend_reg & (btn_pend_reg - 1'b1);
    assign last_now = move_pend_reg ? !(|btn_pend_reg) : !(|btn_rem);
    assign pop = pop_valid && (!busy || (emit && last_now));

    always_comb
    begin
        cmd_next = cmd_reg;
        move_pend_next = move_pend_reg;
        btn_pend_next = btn_pend_reg;
        out_valid_next = out_valid_reg && !evt_out.ready;
        kind_next = kind_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        btn_next = btn_reg;
        last_next = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            last_next = last_now;
            if (move_pend_reg)
            begin
                kind_next = KIND_MOVE;
                dx_next = cmd_reg.dx;
                dy_next = 9'd0 - {cmd_reg.dy_raw[7], cmd_reg.dy_raw};
                btn_next = 2'd0;
                move_pend_next = 1'b0;
            end
            else
            begin
                dx_next = '0;
                dy_next = '0;
                btn_next = 2'd3;
                kind_next = cmd_reg.buttons[2] ? KIND_PRESS : KIND_RELEASE;
                if (btn_pend_reg[0])
                begin
                    btn_next = 2'd1;
                    kind_next = cmd_reg.buttons[0] ? KIND_PRESS : KIND_RELEASE;
                end
                else if (btn_pend_reg[1])
                begin
                    btn_next = 2'd2;
                    kind_next = cmd_reg.buttons[1] ? KIND_PRESS : KIND_RELEASE;
                end
                btn_pend_next = btn_rem;
            end
        end
        if (pop)
        begin
            cmd_next = pop_cmd;
            move_pend_next = pop_cmd.move;
            btn_pend_next = pop_cmd.changed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_pend_reg <= 1'b0;
            btn_pend_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            move_pend_reg <= move_pend_next;
            btn_pend_reg <= btn_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        kind_reg <= kind_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        btn_reg <= btn_next;
        last_reg <= last_next;
    end

    assign evt_out.valid = out_valid_reg;
    assign evt_out.event_kind = kind_reg;
    assign evt_out.delta_x = dx_reg;
    assign evt_out.delta_y = dy_reg;
    assign evt_out.button_number = btn_reg;
    assign evt_out.last_event = last_reg;

endmodule

FILE: sv/ps2_mouse_packet_decoder_core.sv
// top level: ps2 mouse three-byte packet decoder
//
// pkt_in takes one controller transaction per cycle (status byte, data byte);
// transactions without the aux data flag (status bit 5) are dropped
// every third aux transaction completes a packet; when events are enabled
// the packet becomes up to four transactions on evt_out: a move event when
// dx or dy is nonzero, then one press or release per changed button 1 to 3,
// with last_event marking the final one of the packet
// after its third byte, the first event of a packet passes the queue, the
// command register and the output register; throughput: the event generator
// issues one event per cycle while evt_out is ready; pkt_in runs one
// transaction per cycle as long as the two-entry packet queue has room
// a stall on evt_out holds the output register, fills the queue and then
// drops pkt_in.ready; nothing is lost
// reset clears byte position, button state, queue and output valid, and
// sets events_enabled; cfg_we writes cfg_wdata into events_enabled
module ps2_mouse_packet_decoder_core
    import ps2md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    ps2md_in_if.sink    pkt_in,
    ps2md_out_if.source evt_out
);

    logic events_enabled_reg;
    logic push, push_ready, pop, pop_valid;
    cmd_t push_cmd, pop_cmd;

    // enable register, reset to enabled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            events_enabled_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            events_enabled_reg <= cfg_wdata;
        end
    end

    // packet assembly and change detection
    ps2md_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .events_enabled (events_enabled_reg),
        .pkt_in         (pkt_in),
        .push           (push),
        .push_cmd       (push_cmd),
        .push_ready     (push_ready)
    );

    // decouples packet intake from event issue
    ps2md_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid)
    );

    // event generator with registered output
    ps2md_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .evt_out   (evt_out)
    );

endmodule

FILE: verif/ps2md_event_checker.sv
// checker: predicts mouse events from accepted controller transactions and compares them
`timescale 1ns / 100ps

module ps2md_event_checker
    import ps2md_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    ps2md_in_if  pkt,
    ps2md_out_if evt,
    output int   fail_count,
    output int   pending
);

    typedef struct {
        event_kind_t       kind;
        logic signed [7:0] dx;
        logic signed [8:0] dy;
        logic [1:0]        button;
        logic              last;
    } mouse_event_t;

    mouse_event_t expected_events[$];

    logic [7:0] packet_buf [3];
    logic [1:0] byte_pos;
    logic [2:0] held_buttons;
    logic       events_on;
    int         mismatches = 0;
    int         waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    // store one aux byte; on a completed packet queue the events it causes
    task automatic absorb_aux_byte(input logic [7:0] data);
        mouse_event_t batch [4];
        int           n;
        logic [2:0]   now_buttons;
        n = 0;
        packet_buf[byte_pos] = data;
        byte_pos = (byte_pos == LAST_BYTE_POS) ? 2'd0 : byte_pos + 2'd1;
        if (!events_on || byte_pos != 2'd0)
            return;
        if (packet_buf[1] != 8'd0 || packet_buf[2] != 8'd0)
        begin
            batch[n].kind   = KIND_MOVE;
            batch[n].dx     = $signed(packet_buf[1]);
            batch[n].dy     = -$signed({packet_buf[2][7], packet_buf[2]});
            batch[n].button = 2'd0;
            batch[n].last   = 1'b0;
            n++;
        end
        now_buttons = packet_buf[0][2:0];
        for (int b = 0; b < BUTTON_COUNT; b++)
        begin
            if (now_buttons[b] != held_buttons[b])
            begin
                batch[n].kind   = now_buttons[b] ? KIND_PRESS : KIND_RELEASE;
                batch[n].dx     = '0;
                batch[n].dy     = '0;
                batch[n].button = 2'(b + 1);
                batch[n].last   = 1'b0;
                n++;
            end
        end
        held_buttons = now_buttons;
        if (n > 0)
            batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_events.push_back(batch[i]);
    endtask

    task automatic check_event();
        mouse_event_t want;
        if (expected_events.size() == 0)
        begin
            $error("unexpected event transaction: event_kind %0d", evt.event_kind);
            mismatches++;
            return;
        end
        want = expected_events.pop_front();
        if (evt.event_kind !== want.kind)
        begin
            $error("event_kind: expected %0d, got %0d", want.kind, evt.event_kind);
            mismatches++;
        end
        if (evt.delta_x !== want.dx)
        begin
            $error("delta_x: expected %0d, got %0d", want.dx, evt.delta_x);
            mismatches++;
        end
        if (evt.delta_y !== want.dy)
        begin
            $error("delta_y: expected %0d, got %0d", want.dy, evt.delta_y);
            mismatches++;
        end
        if (evt.button_number !== want.button)
        begin
            $error("button_number: expected %0d, got %0d", want.button, evt.button_number);
            mismatches++;
        end
        if (evt.last_event !== want.last)
        begin
            $error("last_event: expected %0d, got %0d", want.last, evt.last_event);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos     = '0;
            held_buttons = '0;
            events_on    = 1'b1;
            expected_events.delete();
            waiting      = 0;
        end
        else
        begin
            if (evt.valid && evt.ready)
                check_event();
            if (pkt.valid && pkt.ready && pkt.status_byte[AUX_DATA_BIT])
                absorb_aux_byte(pkt.data_byte);
            if (cfg_we)
                events_on = cfg_wdata;
            waiting = expected_events.size();
        end
    end

endmodule

FILE: verif/tb_ps2_mouse_packet_decoder_core.sv
// testbench top: drives controller transactions and event stalls, gives the verdict
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_decoder_core;
    import ps2md_pkg::*;

    // cycles with no transaction on either channel before giving up
    localparam int STALL_LIMIT = 1000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   quiet = 1'b0;
    int   idle_pct = 25;

    ps2md_in_if  pkt_ch ();
    ps2md_out_if evt_ch ();

    ps2_mouse_packet_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pkt_in    (pkt_ch),
        .evt_out   (evt_ch)
    );

    ps2md_event_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .pkt        (pkt_ch),
        .evt        (evt_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // one controller transaction; an optional idle burst first, then hold
    // valid until the decoder takes it (valid stays high for the next one)
    task automatic send_item(input logic [7:0] st, input logic [7:0] dt);
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            pkt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        pkt_ch.valid       <= 1'b1;
        pkt_ch.status_byte <= st;
        pkt_ch.data_byte   <= dt;
        @(posedge clk);
        while (!pkt_ch.ready)
            @(posedge clk);
    endtask

    // three aux bytes: button byte, dx, dy
    task automatic send_packet(input logic [7:0] b0, input logic [7:0] dx, input logic [7:0] dy);
        send_item(8'h20, b0);
        send_item(8'h28, dx);
        send_item(8'h20, dy);
    endtask

    // register writes happen only with the decoder drained; a packet that
    // produces no events may still be inside, so give it the pipeline depth
    task automatic set_events_enabled(input logic en);
        pkt_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // event sink: random stall bursts, long ready stretches, none when quiet
    initial
    begin
        int run;
        evt_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                run = 1;
                evt_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                run = $urandom_range(1, 13);
                evt_ch.ready <= 1'b0;
            end
            else
            begin
                run = $urandom_range(1, 24);
                evt_ch.ready <= 1'b1;
            end
            repeat (run) @(posedge clk);
        end
    end

    // watchdog: any accepted transaction on either side counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pkt_ch.valid && pkt_ch.ready) || (evt_ch.valid && evt_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ps2_mouse_packet_decoder_core: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int         slot;
        int         quota;
        logic [7:0] st;
        logic [7:0] dt;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= 1'b0;
        pkt_ch.valid       <= 1'b0;
        pkt_ch.status_byte <= 8'h00;
        pkt_ch.data_byte   <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // non-aux transactions are dropped, whatever the other status bits
        send_item(8'h00, 8'hFF);
        send_item(8'hDF, 8'hA5);
        // events enabled out of reset; extreme motion, all buttons pressed
        send_item(8'h20, 8'h07);
        send_item(8'hFF, 8'h7F);
        send_item(8'h20, 8'h80);
        // opposite extremes, all released, with a dropped byte mid-packet
        send_item(8'h3F, 8'hF8);
        send_item(8'h20, 8'h80);
        send_item(8'hC0, 8'h55);
        send_item(8'h20, 8'h7F);
        // no motion and no button change: nothing comes out
        send_packet(8'h08, 8'h00, 8'h00);
        // only dy moves; buttons 1 and 3 pressed
        send_packet(8'h05, 8'h00, 8'h01);
        // move plus three button changes, the most events one packet gives
        send_packet(8'h02, 8'h01, 8'h00);
        // disabled: bytes still counted, button state left alone
        set_events_enabled(1'b0);
        send_packet(8'h07, 8'h10, 8'h10);
        set_events_enabled(1'b1);
        // button 2 release shows the held state did not move while disabled
        send_packet(8'h00, 8'h00, 8'h00);

        // random part: alternating enabled and disabled phases; phase lengths
        // are not multiples of three, so packets straddle register writes
        slot = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            set_events_enabled(phase % 2 == 0);
            quota    = (phase % 2 == 0) ? 103 : 22;
            idle_pct = $urandom_range(0, 40);
            for (int i = 0; i < quota; i++)
            begin
                if (phase == 4 && i >= 60)
                    quiet = 1'b1;
                // occasional dropped transactions between packet bytes
                while ($urandom_range(0, 7) == 0)
                    send_item(8'($urandom) & ~(8'd1 << AUX_DATA_BIT), 8'($urandom));
                st = 8'($urandom) | (8'd1 << AUX_DATA_BIT);
                if (slot == 0)
                    dt = 8'($urandom);
                else
                    dt = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
                send_item(st, dt);
                slot = (slot == 2) ? 0 : slot + 1;
            end
        end

        // drain, then let the pipeline settle so late extras get caught
        pkt_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ps2_mouse_packet_decoder_core: match");
        else
            $display("ps2_mouse_packet_decoder_core: mismatch");
        $finish;
    end

endmodule
